/* rtl/rrtd_pkg.sv */
// Package for the round-robin task dispatcher.
// Holds widths, default sizes, request codes, the controller state type and
// the command/status structs shared by the controller and the datapath.
package rrtd_pkg;

    localparam int WORKERS_DEF = 4;
    localparam int DEPTH_DEF   = 16;

    localparam int TASK_W     = 32;
    localparam int SEL_W      = 2;
    localparam int S_TDATA_W  = 40;  // task_word + worker_sel, padded to bytes
    localparam int M_TDATA_W  = 40;  // worker_used + task_out, padded to bytes

    localparam logic FUNC_SUBMIT = 1'b0;
    localparam logic FUNC_TAKE   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FETCH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming request word
        logic exec;      // search, update ring pointers, start the store access
        logic load;      // move the finished result into the output register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_valid; // output register holds a word
        logic out_taken; // receiver is ready to take the word this cycle
    } dp_status_t;

endpackage

/* rtl/rrtd_ctrl.sv */
// Sequencer for the round-robin task dispatcher.
// Steps one request through capture, execute and fetch; uses rrtd_pkg.
module rrtd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  rrtd_pkg::dp_status_t   status,
    output rrtd_pkg::ctrl_cmd_t    cmd
);
    import rrtd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.load    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                // hold until the output register is free or being emptied
                if (!status.out_valid || status.out_taken)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/rrtd_datapath.sv */
// Datapath of the round-robin task dispatcher: ring pointers, start pointer,
// task store memory, queue search and output register. Uses rrtd_pkg.
module rrtd_datapath #(
    parameter int WORKERS = rrtd_pkg::WORKERS_DEF,
    parameter int DEPTH   = rrtd_pkg::DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rrtd_pkg::ctrl_cmd_t              cmd,
    output rrtd_pkg::dp_status_t             status,
    input  logic [rrtd_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rrtd_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tuser
);
    import rrtd_pkg::*;

    localparam int WIDX    = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int PW      = $clog2(DEPTH);
    localparam int ENTRIES = WORKERS * DEPTH;
    localparam int AW      = $clog2(ENTRIES);
    localparam logic [PW-1:0]   PTR_LAST  = PW'(DEPTH - 1);
    localparam logic [WIDX-1:0] WRK_LAST  = WIDX'(WORKERS - 1);
    localparam logic [WIDX:0]   WRK_COUNT = (WIDX + 1)'(WORKERS);
    localparam logic [AW-1:0]   DEPTH_A   = AW'(DEPTH);

    // request latched at acceptance
    logic              req_func_reg;
    logic [TASK_W-1:0] req_task_reg;
    logic [SEL_W-1:0]  req_sel_reg;

    logic [PW-1:0]   rd_reg [WORKERS];
    logic [PW-1:0]   wr_reg [WORKERS];
    logic [WIDX-1:0] start_reg;

    logic [TASK_W-1:0] mem [ENTRIES];
    logic [TASK_W-1:0] rdata_reg;

    logic              res_ok_reg;
    logic              res_take_reg;
    logic [SEL_W-1:0]  res_worker_reg;

    logic              out_valid_reg;
    logic              out_ok_reg;
    logic [SEL_W-1:0]  out_worker_reg;
    logic [TASK_W-1:0] out_task_reg;

    logic [PW-1:0]   wr_inc [WORKERS];
    logic [WORKERS-1:0] full;
    logic            found;
    logic [WIDX-1:0] pick;
    logic            sel_ok;
    logic [WIDX-1:0] sel_idx;
    logic            take_ok;
    logic [PW-1:0]   rd_cur;
    logic [PW-1:0]   rd_inc;
    logic [WIDX-1:0] start_inc;
    logic            do_write;
    logic            do_read;
    logic [AW-1:0]   waddr;
    logic [AW-1:0]   raddr;

    always_comb
    begin
        for (int w = 0; w < WORKERS; w++)
        begin
            wr_inc[w] = (wr_reg[w] == PTR_LAST) ? '0 : wr_reg[w] + PW'(1);
            full[w]   = (wr_inc[w] == rd_reg[w]);
        end
    end

    // first non-full queue counting up from the start pointer, wrapping round
    always_comb
    begin
        logic [WIDX:0] qs;
        found = 1'b0;
        pick  = '0;
        for (int i = WORKERS - 1; i >= 0; i--)
        begin
            qs = (WIDX + 1)'(start_reg) + (WIDX + 1)'(i);
            if (qs >= WRK_COUNT)
            begin
                qs = qs - WRK_COUNT;
            end
            if (!full[qs[WIDX-1:0]])
            begin
                found = 1'b1;
                pick  = qs[WIDX-1:0];
            end
        end
    end

    assign sel_ok    = (32'(req_sel_reg) < 32'(WORKERS));
    assign sel_idx   = sel_ok ? WIDX'(req_sel_reg) : '0;
    assign rd_cur    = rd_reg[sel_idx];
    assign rd_inc    = (rd_cur == PTR_LAST) ? '0 : rd_cur + PW'(1);
    assign take_ok   = sel_ok && (rd_cur != wr_reg[sel_idx]);
    assign start_inc = (start_reg == WRK_LAST) ? '0 : start_reg + WIDX'(1);

    assign do_write = cmd.exec && (req_func_reg == FUNC_SUBMIT) && found;
    assign do_read  = cmd.exec && (req_func_reg == FUNC_TAKE) && take_ok;
    assign waddr    = AW'(AW'(pick) * DEPTH_A) + AW'(wr_reg[pick]);
    assign raddr    = AW'(AW'(sel_idx) * DEPTH_A) + AW'(rd_cur);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_func_reg <= s_tuser;
            req_task_reg <= s_tdata[TASK_W-1:0];
            req_sel_reg  <= s_tdata[TASK_W+SEL_W-1:TASK_W];
        end
        if (cmd.exec)
        begin
            if (req_func_reg == FUNC_SUBMIT)
            begin
                res_ok_reg     <= found;
                res_worker_reg <= found ? SEL_W'(pick) : '0;
                res_take_reg   <= 1'b0;
            end
            else
            begin
                res_ok_reg     <= take_ok;
                res_worker_reg <= req_sel_reg;
                res_take_reg   <= 1'b1;
            end
        end
        if (cmd.load)
        begin
            out_ok_reg     <= res_ok_reg;
            out_worker_reg <= res_worker_reg;
            out_task_reg   <= (res_take_reg && res_ok_reg) ? rdata_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[waddr] <= req_task_reg;
        end
        if (do_read)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < WORKERS; w++)
            begin
                rd_reg[w] <= '0;
                wr_reg[w] <= '0;
            end
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec && (req_func_reg == FUNC_SUBMIT))
            begin
                start_reg <= start_inc;
            end
            if (do_write)
            begin
                wr_reg[pick] <= wr_inc[pick];
            end
            if (do_read)
            begin
                rd_reg[sel_idx] <= rd_inc;
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_valid = out_valid_reg;
    assign status.out_taken = m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = {(M_TDATA_W - SEL_W - TASK_W)'(0), out_task_reg, out_worker_reg};

endmodule

/* rtl/round_robin_task_dispatcher.sv */
// Top level of the round-robin task dispatcher.
// Joins rrtd_ctrl and rrtd_datapath; uses rrtd_pkg.
//
// Usage:
//   Slave side (s_*) carries requests. s_tuser is the request kind (submit or
//   take), s_tdata holds the task word and the worker to pop from. Every
//   request yields exactly one result word on the master side (m_*):
//   m_tuser is the success flag, m_tdata the queue used and the popped task.
//   A submit goes to the first non-full queue counting from a round-robin
//   start that moves on with every submit; a take pops the named queue.
//   Each queue holds DEPTH-1 tasks.
//
// Timing:
//   One request is in flight at a time. A result word passes through capture,
//   execute and fetch before it appears; the next request is taken in the
//   cycle after the result is loaded, so no new request is taken before the
//   last one is through. The fetch step allows for the registered read port
//   of the task store memory.
//
// Reset drops all queues to empty and the start pointer to worker 0; no
// clearing pass is needed. When the receiver stalls, the result word holds
// in the output register; one further request may finish into the fetch
// stage and then waits there until the output register frees.
module round_robin_task_dispatcher #(
    parameter int WORKERS = rrtd_pkg::WORKERS_DEF,
    parameter int DEPTH   = rrtd_pkg::DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // bits [31:0] task_word, [33:32] worker_sel, [39:34] zero
    input  logic [rrtd_pkg::S_TDATA_W-1:0]   s_tdata,
    // bit [0] func
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // bits [1:0] worker_used, [33:2] task_out, [39:34] zero
    output logic [rrtd_pkg::M_TDATA_W-1:0]   m_tdata,
    // bit [0] ok
    output logic                             m_tuser
);
    import rrtd_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequence each request
    rrtd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // hold rings, store and result
    rrtd_datapath #(
        .WORKERS (WORKERS),
        .DEPTH   (DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* rtl/rrtd_checker.sv */
// Port-level checks for the round-robin task dispatcher.
// Bound to round_robin_task_dispatcher; uses rrtd_pkg widths.
module rrtd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [rrtd_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                             m_tuser
);
    import rrtd_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // one request at a time: busy right after acceptance
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // with a free output, the result shows once capture, execute and fetch are done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |-> ##3 m_tvalid)
        else $error("result word late");

    // a failed request never carries a task
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[TASK_W+SEL_W-1:SEL_W] == '0)
        else $error("failed request carries a task");

endmodule

bind round_robin_task_dispatcher rrtd_checker u_rrtd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
